// ----- rtl/partial_heapsort_top_k_top_defines.svh -----
// Assertion macros for the partial heapsort top-k block.
// Used by the port checker; needs clk and rst_n in the enclosing scope.
`ifndef PARTIAL_HEAPSORT_TOP_K_TOP_DEFINES_SVH
`define PARTIAL_HEAPSORT_TOP_K_TOP_DEFINES_SVH

// Check a property while out of reset.
`define PHTK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("phtk check failed");

// Check a property at every edge, reset included.
`define PHTK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("phtk check failed");

`endif

// ----- rtl/phtk_pkg.sv -----
// Package for the partial heapsort top-k block.
// Holds transaction types, entry type, opcodes and the controller states.
`default_nettype none

package phtk_pkg;

  localparam int KEY_W = 12;
  localparam int TAG_W = 8;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] K_RESET = 5'd10;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic             last;
    logic             empty_res;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIN_WR,
    ST_UP_CMP,
    ST_ROOT_CHK,
    ST_SD_RD,
    ST_SD_CMP,
    ST_SORT_RD,
    ST_SORT_SW,
    ST_EMIT,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/partial_heapsort_top_k_top.sv -----
// Top level of the partial heapsort top-k block: heap memory and its controller.
// Depends on phtk_pkg.
//
// channel  ports                         handshake
// -------  ----------------------------  ------------------------------------
// input    start, busy, in_data          taken when start && !busy
// result   out_strobe, out_data          one-cycle strobe per result, no back-pressure
// config   cfg_we, cfg_wdata             k_limit written when cfg_we
//
// Push: appended and sifted up while below k entries; when full, dropped, or else
//   replaces the root and sinks. Finish with n entries: each root is extracted
//   and the rest sunk, then results leave one per cycle, the last in the first idle
//   cycle. Finish with nothing held: busy stays low, one result next cycle.
// Synchronous reset empties the heap at once; memory contents are not cleared.
`default_nettype none

module partial_heapsort_top_k_top #(
  parameter int MAX_K = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  phtk_pkg::in_item_t              in_data,
  output logic                            out_strobe,
  output phtk_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [phtk_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int AW = $clog2(MAX_K);

  phtk_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       e_r, e_nxt;
  logic [phtk_pkg::CFG_W-1:0] klim_r;
  phtk_pkg::entry_t    item_r, item_nxt;
  logic                sorting_r, sorting_nxt;
  logic                emit_vld_r, emit_vld_nxt;
  logic                emit_last_r, emit_last_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  phtk_pkg::out_item_t out_data_r, out_data_nxt;
  logic                empty_pulse;

  phtk_pkg::entry_t    mem [MAX_K];
  phtk_pkg::entry_t    rd_a_r, rd_b_r;
  logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
  logic                wr_en;
  phtk_pkg::entry_t    wr_data;

  logic [CW-1:0]       eff_k;
  logic                accept;
  logic [CW-1:0]       up_i;
  logic [CW-1:0]       parent;
  logic [CW:0]         c_full;
  logic [CW-1:0]       c_idx, c1_idx;
  logic                sd_has_child, c_only, pick_left, sd_swap;
  phtk_pkg::entry_t    child;
  logic [CW-1:0]       child_idx;
  logic                up_swap, root_less;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] idx);
    logic [CW-1:0] m;
    m = idx - CW'(1);
    return m[AW-1:0];
  endfunction

  always_comb begin
    if (int'(klim_r) > MAX_K) begin
      eff_k = CW'(MAX_K);
    end else if (klim_r == '0) begin
      eff_k = CW'(1);
    end else begin
      eff_k = CW'(klim_r);
    end
  end

  assign busy         = (state_r != phtk_pkg::ST_IDLE);
  assign accept       = start && !busy;
  assign up_i         = cnt_r + CW'(1);
  assign parent       = i_r >> 1;
  assign c_full       = {i_r, 1'b0};
  assign c_idx        = c_full[CW-1:0];
  assign c1_idx       = c_idx + CW'(1);
  assign sd_has_child = (c_full <= {1'b0, n_r});
  assign c_only       = (c_full == {1'b0, n_r});
  assign pick_left    = c_only || (rd_a_r.key > rd_b_r.key);
  assign child        = pick_left ? rd_a_r : rd_b_r;
  assign child_idx    = pick_left ? c_idx : c1_idx;
  assign sd_swap      = (item_r.key < child.key);
  assign up_swap      = (item_r.key > rd_a_r.key);
  assign root_less    = (item_r.key < rd_a_r.key);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phtk_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == phtk_pkg::OP_PUSH) begin
            if (cnt_r < eff_k) begin
              state_nxt = (up_i == CW'(1)) ? phtk_pkg::ST_FIN_WR : phtk_pkg::ST_UP_CMP;
            end else begin
              state_nxt = phtk_pkg::ST_ROOT_CHK;
            end
          end else if (cnt_r != '0) begin
            state_nxt = phtk_pkg::ST_SORT_RD;
          end
        end
      end
      phtk_pkg::ST_FIN_WR: state_nxt = phtk_pkg::ST_IDLE;
      phtk_pkg::ST_UP_CMP: begin
        if (!up_swap) begin
          state_nxt = phtk_pkg::ST_IDLE;
        end else if (parent == CW'(1)) begin
          state_nxt = phtk_pkg::ST_FIN_WR;
        end
      end
      phtk_pkg::ST_ROOT_CHK: begin
        state_nxt = root_less ? phtk_pkg::ST_SD_RD : phtk_pkg::ST_IDLE;
      end
      phtk_pkg::ST_SD_RD: begin
        if (sd_has_child) begin
          state_nxt = phtk_pkg::ST_SD_CMP;
        end else begin
          state_nxt = sorting_r ? phtk_pkg::ST_SORT_RD : phtk_pkg::ST_IDLE;
        end
      end
      phtk_pkg::ST_SD_CMP: begin
        if (sd_swap) begin
          state_nxt = phtk_pkg::ST_SD_RD;
        end else begin
          state_nxt = sorting_r ? phtk_pkg::ST_SORT_RD : phtk_pkg::ST_IDLE;
        end
      end
      phtk_pkg::ST_SORT_RD: begin
        state_nxt = (n_r <= CW'(1)) ? phtk_pkg::ST_EMIT : phtk_pkg::ST_SORT_SW;
      end
      phtk_pkg::ST_SORT_SW: state_nxt = phtk_pkg::ST_SD_RD;
      phtk_pkg::ST_EMIT: begin
        if (e_r == cnt_r) begin
          state_nxt = phtk_pkg::ST_DRAIN;
        end
      end
      phtk_pkg::ST_DRAIN: state_nxt = phtk_pkg::ST_IDLE;
      default: state_nxt = phtk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    item_nxt      = item_r;
    sorting_nxt   = sorting_r;
    emit_vld_nxt  = 1'b0;
    emit_last_nxt = 1'b0;
    empty_pulse   = 1'b0;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    wr_en         = 1'b0;
    wr_addr       = addr_of(i_r);
    wr_data       = item_r;
    case (state_r)
      phtk_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt.key = in_data.key;
          item_nxt.tag = in_data.tag;
          if (in_data.opcode == phtk_pkg::OP_PUSH) begin
            sorting_nxt = 1'b0;
            if (cnt_r < eff_k) begin
              cnt_nxt   = up_i;
              i_nxt     = up_i;
              rd_a_addr = addr_of(up_i >> 1);
            end else begin
              rd_a_addr = addr_of(CW'(1));
            end
          end else if (cnt_r == '0) begin
            empty_pulse = 1'b1;
          end else begin
            sorting_nxt = 1'b1;
            n_nxt       = cnt_r;
          end
        end
      end
      phtk_pkg::ST_FIN_WR: begin
        wr_en = 1'b1;
      end
      phtk_pkg::ST_UP_CMP: begin
        wr_en = 1'b1;
        if (up_swap) begin
          wr_data   = rd_a_r;
          i_nxt     = parent;
          rd_a_addr = addr_of(parent >> 1);
        end
      end
      phtk_pkg::ST_ROOT_CHK: begin
        i_nxt = CW'(1);
        n_nxt = cnt_r;
      end
      phtk_pkg::ST_SD_RD: begin
        if (sd_has_child) begin
          rd_a_addr = addr_of(c_idx);
          rd_b_addr = c_only ? addr_of(c_idx) : addr_of(c1_idx);
        end else begin
          wr_en = 1'b1;
        end
      end
      phtk_pkg::ST_SD_CMP: begin
        wr_en = 1'b1;
        if (sd_swap) begin
          wr_data = child;
          i_nxt   = child_idx;
        end
      end
      phtk_pkg::ST_SORT_RD: begin
        if (n_r <= CW'(1)) begin
          e_nxt = CW'(1);
        end else begin
          rd_a_addr = addr_of(CW'(1));
          rd_b_addr = addr_of(n_r);
        end
      end
      phtk_pkg::ST_SORT_SW: begin
        wr_en    = 1'b1;
        wr_addr  = addr_of(n_r);
        wr_data  = rd_a_r;
        item_nxt = rd_b_r;
        n_nxt    = n_r - CW'(1);
        i_nxt    = CW'(1);
      end
      phtk_pkg::ST_EMIT: begin
        rd_a_addr     = addr_of(e_r);
        emit_vld_nxt  = 1'b1;
        emit_last_nxt = (e_r == cnt_r);
        if (e_r == cnt_r) begin
          cnt_nxt = '0;
        end else begin
          e_nxt = e_r + CW'(1);
        end
      end
      phtk_pkg::ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_strobe_nxt = emit_vld_r || empty_pulse;
    if (empty_pulse) begin
      out_data_nxt.out_key   = '0;
      out_data_nxt.out_tag   = '0;
      out_data_nxt.last      = 1'b1;
      out_data_nxt.empty_res = 1'b1;
    end else begin
      out_data_nxt.out_key   = rd_a_r.key;
      out_data_nxt.out_tag   = rd_a_r.tag;
      out_data_nxt.last      = emit_last_r;
      out_data_nxt.empty_res = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= phtk_pkg::ST_IDLE;
      cnt_r        <= '0;
      sorting_r    <= 1'b0;
      emit_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      klim_r       <= phtk_pkg::K_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sorting_r    <= sorting_nxt;
      emit_vld_r   <= emit_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        klim_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    e_r         <= e_nxt;
    item_r      <= item_nxt;
    emit_last_r <= emit_last_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/phtk_checker.sv -----
// Port checker for the partial heapsort top-k block, bound to the top level.
// Depends on phtk_pkg and partial_heapsort_top_k_top_defines.svh.
`default_nettype none

`include "partial_heapsort_top_k_top_defines.svh"

module phtk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input phtk_pkg::in_item_t  in_data,
  input logic                out_strobe,
  input phtk_pkg::out_item_t out_data
);

  logic empty_hit;

  assign empty_hit = out_strobe && out_data.empty_res;

  `PHTK_ASSERT(a_empty_is_last, empty_hit |-> out_data.last)
  `PHTK_ASSERT(a_empty_is_zero, empty_hit |-> out_data.out_key == '0 && out_data.out_tag == '0)
  `PHTK_ASSERT(a_run_unbroken, out_strobe && !out_data.last |=> out_strobe && !out_data.empty_res)
  `PHTK_ASSERT(a_push_goes_busy, start && !busy && in_data.opcode == phtk_pkg::OP_PUSH |=> busy)
  `PHTK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe)

endmodule

bind partial_heapsort_top_k_top phtk_checker u_phtk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
